/* src/cc20_pkg.sv */
// shared types, constants and the quarter-round function of the chacha20 block
package cc20_pkg;

	localparam int DoubleRoundsDefault = 10;
	localparam int BlockWords = 16;
	localparam int CfgIndexWidth = 3;
	localparam int CfgDataWidth = 64;

	localparam logic [31:0] Sigma0 = 32'h6170_7865;
	localparam logic [31:0] Sigma1 = 32'h3320_646e;
	localparam logic [31:0] Sigma2 = 32'h7962_2d32;
	localparam logic [31:0] Sigma3 = 32'h6b20_6574;

	localparam logic [CfgIndexWidth-1:0] RegKeyWord0 = 3'd0;
	localparam logic [CfgIndexWidth-1:0] RegKeyWord1 = 3'd1;
	localparam logic [CfgIndexWidth-1:0] RegKeyWord2 = 3'd2;
	localparam logic [CfgIndexWidth-1:0] RegKeyWord3 = 3'd3;
	localparam logic [CfgIndexWidth-1:0] RegNonceLow = 3'd4;
	localparam logic [CfgIndexWidth-1:0] RegNonceHigh = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINAL
	} cc20_state_t;

	// controller to datapath
	typedef struct packed {
		logic load_init;
		logic do_round;
		logic diag;
		logic finish;
		logic emit_direct;
	} cc20_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pos_zero;
		logic out_full;
	} cc20_sts_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} cc20_quad_t;

	function automatic cc20_quad_t cc20_quarter(cc20_quad_t q);
		cc20_quad_t r;
		r = q;
		r.a = r.a + r.b;
		r.d = r.d ^ r.a;
		r.d = {r.d[15:0], r.d[31:16]};
		r.c = r.c + r.d;
		r.b = r.b ^ r.c;
		r.b = {r.b[19:0], r.b[31:20]};
		r.a = r.a + r.b;
		r.d = r.d ^ r.a;
		r.d = {r.d[23:0], r.d[31:24]};
		r.c = r.c + r.d;
		r.b = r.b ^ r.c;
		r.b = {r.b[24:0], r.b[31:25]};
		return r;
	endfunction

endpackage

/* src/cc20_ctrl.sv */
// controller: sequences block generation and the input handshake
module cc20_ctrl import cc20_pkg::*; #(
	parameter int DOUBLE_ROUNDS = DoubleRoundsDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic      out_stall,
	input  cc20_sts_t sts,
	output cc20_cmd_t cmd
);

	localparam int RoundsTotal = 2 * DOUBLE_ROUNDS;
	localparam int RoundWidth = $clog2(RoundsTotal);
	localparam logic [RoundWidth-1:0] RoundLast = RoundWidth'(RoundsTotal - 1);

	cc20_state_t state_q, state_d;
	logic [RoundWidth-1:0] rnd_q, rnd_d;
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q <= '0;
		end else begin
			state_q <= state_d;
			rnd_q <= rnd_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rnd_d = rnd_q;
		cmd = '0;
		// output register must be free or draining this cycle
		in_stall = !((state_q == ST_IDLE) && (!sts.out_full || !out_stall));
		accept = in_valid && !in_stall;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (sts.pos_zero) begin
						cmd.load_init = 1'b1;
						rnd_d = '0;
						state_d = ST_ROUND;
					end else begin
						cmd.emit_direct = 1'b1;
					end
				end
			end
			ST_ROUND: begin
				cmd.do_round = 1'b1;
				cmd.diag = rnd_q[0];
				if (rnd_q == RoundLast) begin
					rnd_d = '0;
					state_d = ST_FINAL;
				end else begin
					rnd_d = rnd_q + 1'b1;
				end
			end
			ST_FINAL: begin
				cmd.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
				rnd_d = '0;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_idle_rnd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_ROUND |-> rnd_q == '0)
		else $error("round counter not cleared outside rounds");
	a_rounds_to_final: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == RoundLast) |=> state_q == ST_FINAL)
		else $error("last round did not lead to final add");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall)
		else $error("input taken while a block is in progress");
`endif

endmodule

/* src/cc20_core.sv */
// datapath: configuration, chacha20 state, keystream xor and output register
module cc20_core import cc20_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [CfgDataWidth-1:0]  cfg_data,
	input  logic [7:0]               data_byte,
	input  logic                     last_byte,
	input  logic                     out_stall,
	output logic                     out_valid,
	output logic [7:0]               out_byte,
	output logic                     out_last,
	input  cc20_cmd_t                cmd,
	output cc20_sts_t                sts
);

	logic [63:0] key_q [4];
	logic [63:0] nonce_low_q;
	logic [31:0] nonce_high_q;
	logic [31:0] counter_q;
	logic [5:0]  pos_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic [7:0]  data_q;
	logic        last_q;

	logic [31:0] w_q [BlockWords];
	logic [31:0] init [BlockWords];
	logic [31:0] w_rnd [BlockWords];
	logic [31:0] word_sel;
	logic [7:0]  ks_direct;
	logic [31:0] sum0;

	always_comb begin
		init[0] = Sigma0;
		init[1] = Sigma1;
		init[2] = Sigma2;
		init[3] = Sigma3;
		for (int i = 0; i < 4; i++) begin
			init[4 + 2 * i] = key_q[i][31:0];
			init[5 + 2 * i] = key_q[i][63:32];
		end
		init[12] = counter_q;
		init[13] = nonce_low_q[31:0];
		init[14] = nonce_low_q[63:32];
		init[15] = nonce_high_q;
	end

	// four quarter rounds, on columns or on diagonals
	always_comb begin
		for (int j = 0; j < BlockWords; j++) begin
			w_rnd[j] = w_q[j];
		end
		for (int i = 0; i < 4; i++) begin
			logic [1:0] col;
			logic [1:0] bsel;
			logic [1:0] csel;
			logic [1:0] dsel;
			cc20_quad_t q;
			cc20_quad_t r;
			col = 2'(i);
			bsel = col + (cmd.diag ? 2'd1 : 2'd0);
			csel = col + (cmd.diag ? 2'd2 : 2'd0);
			dsel = col + (cmd.diag ? 2'd3 : 2'd0);
			q.a = w_q[{2'b00, col}];
			q.b = w_q[{2'b01, bsel}];
			q.c = w_q[{2'b10, csel}];
			q.d = w_q[{2'b11, dsel}];
			r = cc20_quarter(q);
			w_rnd[{2'b00, col}] = r.a;
			w_rnd[{2'b01, bsel}] = r.b;
			w_rnd[{2'b10, csel}] = r.c;
			w_rnd[{2'b11, dsel}] = r.d;
		end
	end

	assign word_sel = w_q[pos_q[5:2]];
	assign ks_direct = 8'(word_sel >> {pos_q[1:0], 3'b000});
	assign sum0 = w_q[0] + init[0];

	always_ff @(posedge clk) begin
		if (cmd.load_init) begin
			for (int j = 0; j < BlockWords; j++) begin
				w_q[j] <= init[j];
			end
			data_q <= data_byte;
			last_q <= last_byte;
		end else if (cmd.do_round) begin
			for (int j = 0; j < BlockWords; j++) begin
				w_q[j] <= w_rnd[j];
			end
		end else if (cmd.finish) begin
			// feed-forward leaves the keystream block in the working state
			for (int j = 0; j < BlockWords; j++) begin
				w_q[j] <= w_q[j] + init[j];
			end
		end
		if (cmd.emit_direct) begin
			out_byte_q <= data_byte ^ ks_direct;
			out_last_q <= last_byte;
		end else if (cmd.finish) begin
			out_byte_q <= data_q ^ sum0[7:0];
			out_last_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
			nonce_low_q <= '0;
			nonce_high_q <= '0;
			counter_q <= '0;
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					RegKeyWord0: key_q[0] <= cfg_data;
					RegKeyWord1: key_q[1] <= cfg_data;
					RegKeyWord2: key_q[2] <= cfg_data;
					RegKeyWord3: key_q[3] <= cfg_data;
					RegNonceLow: nonce_low_q <= cfg_data;
					RegNonceHigh: nonce_high_q <= cfg_data[31:0];
					default: ;
				endcase
			end
			if (cmd.emit_direct) begin
				pos_q <= last_byte ? 6'd0 : pos_q + 6'd1;
				counter_q <= last_byte ? 32'd0 : counter_q;
			end else if (cmd.finish) begin
				pos_q <= last_q ? 6'd0 : 6'd1;
				counter_q <= last_q ? 32'd0 : counter_q + 32'd1;
			end
			if (cmd.emit_direct || cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.pos_zero = (pos_q == 6'd0);
	assign sts.out_full = out_valid_q;
	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_direct || cmd.finish) |-> (!out_valid_q || !out_stall))
		else $error("output word overwritten while stalled");
`endif

endmodule

/* src/chacha20_stream_cipher_top.sv */
// top level of the chacha20 byte stream cipher
//
//   channel  signals                                  direction
//   input    in_valid, in_stall, data_byte, last_byte in, stall out
//   output   out_valid, out_stall, out_byte, out_last out, stall in
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data in, ready out (always high)
//
// a byte at block position zero stalls the input after it is taken while its block is
// computed: one round per cycle through four parallel quarter-round units, then a
// feed-forward add that also loads the result word
// other bytes of a block are read straight from the held block
// reset clears configuration, counter, position and the output valid flag; no clearing pass
// a stalled output word holds; the input also stalls while that word cannot drain
module chacha20_stream_cipher_top import cc20_pkg::*; #(
	parameter int DOUBLE_ROUNDS = DoubleRoundsDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [7:0]               data_byte,
	input  logic                     last_byte,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [7:0]               out_byte,
	output logic                     out_last,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [CfgDataWidth-1:0]  cfg_data
);

	cc20_cmd_t cmd;
	cc20_sts_t sts;

	assign cfg_ready = 1'b1;

	cc20_ctrl #(
		.DOUBLE_ROUNDS(DOUBLE_ROUNDS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	cc20_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_byte (out_byte),
		.out_last (out_last),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

/* tb/sv/tb_chacha20_stream_cipher_top.sv */
// self-checking testbench for the chacha20 byte stream cipher top level
`timescale 1ns / 1ps

module tb_chacha20_stream_cipher_top import cc20_pkg::*;;

	localparam int DoubleRounds = DoubleRoundsDefault;
	localparam int PhaseCount = 8;
	localparam int PhaseBytes = 105;
	localparam int QuietLimit = 3000;
	localparam int LongHold = 200;
	localparam logic [CfgIndexWidth-1:0] RegSpare6 = 3'd6;
	localparam logic [CfgIndexWidth-1:0] RegSpare7 = 3'd7;

	typedef enum int {
		CFG_ZERO,
		CFG_ONES,
		CFG_COUNTING,
		CFG_RANDOM
	} cfg_kind_t;

	// keystream predictor and queue of expected cipher bytes
	class keystream_checker;
		int rounds;
		logic [63:0] key_w[4];
		logic [63:0] nonce_lo;
		logic [31:0] nonce_hi;
		logic [31:0] blk_ctr;
		logic [5:0] pos;
		logic [7:0] ks_bytes[64];
		logic [31:0] mix_w[16];
		logic [8:0] expected_out[$];
		int mismatches;
		int bytes_in;
		int messages;
		int blocks;

		function new(int n_rounds);
			rounds = n_rounds;
			for (int k = 0; k < 4; k++)
				key_w[k] = '0;
			nonce_lo = '0;
			nonce_hi = '0;
			blk_ctr = '0;
			pos = '0;
			for (int k = 0; k < 64; k++)
				ks_bytes[k] = '0;
			mismatches = 0;
			bytes_in = 0;
			messages = 0;
			blocks = 0;
		endfunction

		function void set_reg(logic [CfgIndexWidth-1:0] idx, logic [63:0] val);
			case (idx)
				RegKeyWord0: key_w[0] = val;
				RegKeyWord1: key_w[1] = val;
				RegKeyWord2: key_w[2] = val;
				RegKeyWord3: key_w[3] = val;
				RegNonceLow: nonce_lo = val;
				RegNonceHigh: nonce_hi = val[31:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] rotl32(logic [31:0] v, int n);
			return (v << n) | (v >> (32 - n));
		endfunction

		function void qr(int a, int b, int c, int d);
			mix_w[a] = mix_w[a] + mix_w[b];
			mix_w[d] = rotl32(mix_w[d] ^ mix_w[a], 16);
			mix_w[c] = mix_w[c] + mix_w[d];
			mix_w[b] = rotl32(mix_w[b] ^ mix_w[c], 12);
			mix_w[a] = mix_w[a] + mix_w[b];
			mix_w[d] = rotl32(mix_w[d] ^ mix_w[a], 8);
			mix_w[c] = mix_w[c] + mix_w[d];
			mix_w[b] = rotl32(mix_w[b] ^ mix_w[c], 7);
		endfunction

		function void refill_block();
			logic [31:0] init_w[16];
			logic [31:0] sum;
			init_w[0] = Sigma0;
			init_w[1] = Sigma1;
			init_w[2] = Sigma2;
			init_w[3] = Sigma3;
			for (int k = 0; k < 4; k++) begin
				init_w[4 + 2 * k] = key_w[k][31:0];
				init_w[5 + 2 * k] = key_w[k][63:32];
			end
			init_w[12] = blk_ctr;
			init_w[13] = nonce_lo[31:0];
			init_w[14] = nonce_lo[63:32];
			init_w[15] = nonce_hi;
			mix_w = init_w;
			for (int r = 0; r < rounds; r++) begin
				qr(0, 4, 8, 12);
				qr(1, 5, 9, 13);
				qr(2, 6, 10, 14);
				qr(3, 7, 11, 15);
				qr(0, 5, 10, 15);
				qr(1, 6, 11, 12);
				qr(2, 7, 8, 13);
				qr(3, 4, 9, 14);
			end
			// keystream bytes are the little-endian bytes of words 0..15
			for (int w = 0; w < 16; w++) begin
				sum = mix_w[w] + init_w[w];
				for (int b = 0; b < 4; b++)
					ks_bytes[4 * w + b] = sum[8 * b +: 8];
			end
		endfunction

		function void predict_byte(logic [7:0] d, logic l);
			logic [8:0] item;
			if (pos == '0) begin
				refill_block();
				blk_ctr = blk_ctr + 32'd1;
				blocks++;
			end
			item = {l, d ^ ks_bytes[pos]};
			expected_out.insert(expected_out.size(), item);
			bytes_in++;
			if (l) begin
				blk_ctr = '0;
				pos = '0;
				messages++;
			end else begin
				pos = pos + 6'd1;
			end
		endfunction

		function void check_byte(logic [7:0] b, logic l);
			logic [8:0] e;
			if (expected_out.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("output word with nothing pending: byte %02h last %0b", b, l);
				return;
			end
			e = expected_out.pop_front();
			if (e[7:0] !== b || e[8] !== l) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
						e[7:0], e[8], b, l);
			end
		endfunction

		function int pending();
			return expected_out.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] data_byte = '0;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] out_byte;
	logic out_last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIndexWidth-1:0] cfg_index = '0;
	logic [CfgDataWidth-1:0] cfg_data = '0;

	keystream_checker sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	int settings_done = 0;

	chacha20_stream_cipher_top #(
		.DOUBLE_ROUNDS(DoubleRounds)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.out_last(out_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// receiver: random stall, or a long hold-off when requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_byte(out_byte, out_last);
	end

	// watchdog on cycles with no word moving on any channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout after %0d quiet cycles", QuietLimit);
		$display("end of test: mismatches");
		$finish;
	end

	task automatic send_byte(input logic [7:0] d, input logic l);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		last_byte <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.predict_byte(d, l);
	endtask

	task automatic cfg_write(input logic [CfgIndexWidth-1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	function automatic logic [63:0] key_value(cfg_kind_t kind, int k);
		logic [63:0] v;
		case (kind)
			CFG_ZERO: v = '0;
			CFG_ONES: v = '1;
			CFG_COUNTING: begin
				for (int b = 0; b < 8; b++)
					v[8 * b +: 8] = 8'(8 * k + b);
			end
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	// only called with nothing in flight; spare indexes get junk that must be ignored
	task automatic apply_setting(input cfg_kind_t kind);
		while (sb.pending() != 0)
			@(posedge clk);
		cfg_write(RegKeyWord0, key_value(kind, 0));
		cfg_write(RegKeyWord1, key_value(kind, 1));
		cfg_write(RegKeyWord2, key_value(kind, 2));
		cfg_write(RegKeyWord3, key_value(kind, 3));
		case (kind)
			CFG_ZERO: begin
				cfg_write(RegNonceLow, '0);
				cfg_write(RegNonceHigh, '0);
			end
			CFG_ONES: begin
				cfg_write(RegNonceLow, '1);
				cfg_write(RegNonceHigh, '1);
			end
			CFG_COUNTING: begin
				cfg_write(RegNonceLow, 64'h4a00_0000_0900_0000);
				cfg_write(RegNonceHigh, {32'hdead_beef, 32'h0});
			end
			default: begin
				cfg_write(RegNonceLow, {$urandom, $urandom});
				cfg_write(RegNonceHigh, {$urandom, $urandom});
			end
		endcase
		cfg_write(RegSpare6, {$urandom, $urandom});
		cfg_write(RegSpare7, {$urandom, $urandom});
		cfg_valid <= 1'b0;
		settings_done++;
	endtask

	initial begin : stimulus
		int sent;
		int len;
		int pick;
		logic [7:0] d;
		cfg_kind_t kind;

		sb = new(DoubleRounds);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single-byte messages, then walking ones, walking zeros and alternating bytes under the reset key
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		for (int i = 0; i < 20; i++) begin
			if (i < 8)
				d = 8'h01 << i;
			else if (i < 16)
				d = ~(8'h01 << (i - 8));
			else
				d = (i % 2) ? 8'haa : 8'h55;
			send_byte(d, i == 19);
		end
		in_valid <= 1'b0;

		for (int p = 0; p < PhaseCount; p++) begin
			case (p)
				0: kind = CFG_COUNTING;
				2: kind = CFG_ONES;
				4: kind = CFG_ZERO;
				6: kind = CFG_ONES;
				default: kind = CFG_RANDOM;
			endcase
			apply_setting(kind);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
				default: begin send_idle_pct = 12; recv_stall_pct = 12; end
			endcase
			// receiver holds off while the sender keeps pushing
			if (p == 4)
				hold_left = LongHold;
			sent = 0;
			// the last message of a phase may be cut short and carry into the next setting
			while (sent < PhaseBytes) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					len = $urandom_range(1, 40);
				else if (pick < 8)
					len = $urandom_range(41, 130);
				else if (pick == 8)
					len = 63 + $urandom_range(0, 2);
				else
					len = $urandom_range(131, 200);
				for (int i = 0; i < len && sent < PhaseBytes; i++) begin
					if (p == 4 && sent == 60) begin
						in_valid <= 1'b0;
						@(posedge clk);
						while (sb.pending() != 0)
							@(posedge clk);
					end
					send_byte(8'($urandom_range(0, 255)), i == len - 1);
					sent++;
				end
			end
			in_valid <= 1'b0;
		end

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (2 * DoubleRounds + 8) @(posedge clk);

		$display("ran %0d bytes in %0d complete messages over %0d keystream blocks",
			sb.bytes_in, sb.messages, sb.blocks);
		$display("used %0d register settings and four idle patterns, %0d mismatches",
			settings_done, sb.mismatches);
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
